>>> hw/rtl/tdpl_pkg.sv
// ----------------------------------------------------------------------------
// tdpl_pkg
// Shared widths, microcode codes, control/status structs and the control
// store for the trial-division prime lister.
// ----------------------------------------------------------------------------
package tdpl_pkg;

    // Field and datapath widths
    localparam int LIMIT_W   = 9;
    localparam int VALUE_W   = 8;
    localparam int COUNT_W   = 6;
    localparam int DIV_W     = 9;
    localparam int SQ_W      = 10;
    localparam int BITCNT_W  = 4;
    localparam int UPC_W     = 3;
    localparam int MAX_LIMIT_DEF = 256;

    // Datapath operations
    localparam logic [2:0] OP_NOP        = 3'd0;
    localparam logic [2:0] OP_LOAD       = 3'd1;
    localparam logic [2:0] OP_DIV_INIT   = 3'd2;
    localparam logic [2:0] OP_REM_INIT   = 3'd3;
    localparam logic [2:0] OP_REM_STEP   = 3'd4;
    localparam logic [2:0] OP_DIV_INC    = 3'd5;
    localparam logic [2:0] OP_CAND_INC   = 3'd6;
    localparam logic [2:0] OP_EMIT       = 3'd7;

    // Jump conditions
    localparam logic [2:0] CND_NONE      = 3'd0;
    localparam logic [2:0] CND_ALWAYS    = 3'd1;
    localparam logic [2:0] CND_C_GE_B    = 3'd2;
    localparam logic [2:0] CND_SQ_GT_C   = 3'd3;
    localparam logic [2:0] CND_REM_MORE  = 3'd4;
    localparam logic [2:0] CND_REM_NZ    = 3'd5;

    // Hold conditions
    localparam logic [1:0] WAIT_NONE     = 2'd0;
    localparam logic [1:0] WAIT_IN       = 2'd1;
    localparam logic [1:0] WAIT_OUT      = 2'd2;

    // Program addresses
    localparam logic [UPC_W-1:0] UA_IDLE      = 3'd0;
    localparam logic [UPC_W-1:0] UA_CAND      = 3'd1;
    localparam logic [UPC_W-1:0] UA_TRY       = 3'd2;
    localparam logic [UPC_W-1:0] UA_REM       = 3'd3;
    localparam logic [UPC_W-1:0] UA_CHECK     = 3'd4;
    localparam logic [UPC_W-1:0] UA_NEXT      = 3'd5;
    localparam logic [UPC_W-1:0] UA_PRIME     = 3'd6;
    localparam logic [UPC_W-1:0] UA_LAST      = 3'd7;

    typedef struct packed {
        logic [2:0]       op;
        logic [2:0]       cond;
        logic [1:0]       wait_sel;
        logic             last;
        logic [UPC_W-1:0] target;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        logic [2:0] op;
        logic       last;
        logic       exec;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic c_ge_b;
        logic sq_gt_c;
        logic rem_more;
        logic rem_nz;
        logic out_free;
    } stat_t;

    // Control store: one word per step
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        w = '{OP_NOP, CND_ALWAYS, WAIT_NONE, 1'b0, UA_IDLE};
        case (addr)
            UA_IDLE:  w = '{OP_LOAD,     CND_NONE,     WAIT_IN,   1'b0, UA_CAND};
            UA_CAND:  w = '{OP_DIV_INIT, CND_C_GE_B,   WAIT_NONE, 1'b0, UA_LAST};
            UA_TRY:   w = '{OP_REM_INIT, CND_SQ_GT_C,  WAIT_NONE, 1'b0, UA_PRIME};
            UA_REM:   w = '{OP_REM_STEP, CND_REM_MORE, WAIT_NONE, 1'b0, UA_REM};
            UA_CHECK: w = '{OP_DIV_INC,  CND_REM_NZ,   WAIT_NONE, 1'b0, UA_TRY};
            UA_NEXT:  w = '{OP_CAND_INC, CND_ALWAYS,   WAIT_NONE, 1'b0, UA_CAND};
            UA_PRIME: w = '{OP_EMIT,     CND_ALWAYS,   WAIT_OUT,  1'b0, UA_NEXT};
            UA_LAST:  w = '{OP_EMIT,     CND_ALWAYS,   WAIT_OUT,  1'b1, UA_IDLE};
            default:  w = '{OP_NOP,      CND_ALWAYS,   WAIT_NONE, 1'b0, UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/tdpl_sequencer.sv
// ----------------------------------------------------------------------------
// tdpl_sequencer
// Step counter over the control store, with holds on the input and output
// words and conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module tdpl_sequencer
    import tdpl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  idle
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    ucode_t           uw;
    logic             hold;
    logic             take;

    assign uw   = ucode_rom(upc_reg);
    assign idle = (upc_reg == UA_IDLE);

    // Hold the step while its word cannot move
    always_comb
    begin
        case (uw.wait_sel)
            WAIT_IN:  hold = !in_valid;
            WAIT_OUT: hold = !stat.out_free;
            default:  hold = 1'b0;
        endcase
    end

    // Jump condition select
    always_comb
    begin
        case (uw.cond)
            CND_ALWAYS:   take = 1'b1;
            CND_C_GE_B:   take = stat.c_ge_b;
            CND_SQ_GT_C:  take = stat.sq_gt_c;
            CND_REM_MORE: take = stat.rem_more;
            CND_REM_NZ:   take = stat.rem_nz;
            default:      take = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
            upc_next = upc_reg;
        else if (take)
            upc_next = uw.target;
        else
            upc_next = upc_reg + 1'b1;
    end

    assign ctrl.op   = uw.op;
    assign ctrl.last = uw.last;
    assign ctrl.exec = !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= UA_IDLE;
        else
            upc_reg <= upc_next;
    end

endmodule

>>> hw/rtl/tdpl_datapath.sv
// ----------------------------------------------------------------------------
// tdpl_datapath
// Candidate, divisor, square, bit-serial remainder and count registers, plus
// the output word register.
// ----------------------------------------------------------------------------
module tdpl_datapath
    import tdpl_pkg::*;
#(
    parameter int MAX_LIMIT = MAX_LIMIT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_t              ctrl,
    input  logic [LIMIT_W-1:0] limit,
    input  logic               out_stall,
    output stat_t              stat,
    output logic               out_valid,
    output logic [VALUE_W-1:0] prime_value,
    output logic               is_last,
    output logic [COUNT_W-1:0] prime_count
);

    localparam logic [LIMIT_W-1:0] LIM_SAT = LIMIT_W'(MAX_LIMIT);

    logic [LIMIT_W-1:0]  cand_reg,  cand_next;
    logic [LIMIT_W-1:0]  bound_reg, bound_next;
    logic [DIV_W-1:0]    div_reg,   div_next;
    logic [SQ_W-1:0]     sq_reg,    sq_next;
    logic [DIV_W-1:0]    rem_reg,   rem_next;
    logic [BITCNT_W-1:0] bitcnt_reg, bitcnt_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                ov_reg;
    logic [VALUE_W-1:0]  val_reg;
    logic                last_reg;
    logic [COUNT_W-1:0]  cnt_out_reg;

    logic [BITCNT_W-1:0] bit_idx;
    logic [DIV_W:0]      shifted;
    logic                emit;

    assign bit_idx = bitcnt_reg - 1'b1;
    assign shifted = {rem_reg, cand_reg[bit_idx]};
    assign emit    = ctrl.exec && (ctrl.op == OP_EMIT);

    // Status flags
    assign stat.c_ge_b   = (cand_reg >= bound_reg);
    assign stat.sq_gt_c  = (sq_reg > SQ_W'(cand_reg));
    assign stat.rem_more = (bitcnt_reg != BITCNT_W'(1));
    assign stat.rem_nz   = (rem_reg != '0);
    assign stat.out_free = !ov_reg || !out_stall;

    // Working register updates
    always_comb
    begin
        cand_next   = cand_reg;
        bound_next  = bound_reg;
        div_next    = div_reg;
        sq_next     = sq_reg;
        rem_next    = rem_reg;
        bitcnt_next = bitcnt_reg;
        count_next  = count_reg;
        if (ctrl.exec)
        begin
            case (ctrl.op)
                OP_LOAD:
                begin
                    bound_next = (limit > LIM_SAT) ? LIM_SAT : limit;
                    count_next = '0;
                    cand_next  = LIMIT_W'(2);
                end
                OP_DIV_INIT:
                begin
                    div_next = DIV_W'(2);
                    sq_next  = SQ_W'(4);
                end
                OP_REM_INIT:
                begin
                    rem_next    = '0;
                    bitcnt_next = BITCNT_W'(LIMIT_W);
                end
                OP_REM_STEP:
                begin
                    // One restoring step per bit, MSB first
                    if (shifted >= {1'b0, div_reg})
                        rem_next = DIV_W'(shifted - {1'b0, div_reg});
                    else
                        rem_next = DIV_W'(shifted);
                    bitcnt_next = bit_idx;
                end
                OP_DIV_INC:
                begin
                    // (d+1)^2 = d^2 + 2d + 1
                    sq_next  = sq_reg + {div_reg, 1'b1};
                    div_next = div_reg + 1'b1;
                end
                OP_CAND_INC:
                    cand_next = cand_reg + 1'b1;
                OP_EMIT:
                begin
                    if (!ctrl.last)
                        count_next = count_reg + 1'b1;
                end
                default:
                    cand_next = cand_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg   <= LIMIT_W'(2);
            bound_reg  <= '0;
            div_reg    <= DIV_W'(2);
            sq_reg     <= SQ_W'(4);
            rem_reg    <= '0;
            bitcnt_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            cand_reg   <= cand_next;
            bound_reg  <= bound_next;
            div_reg    <= div_next;
            sq_reg     <= sq_next;
            rem_reg    <= rem_next;
            bitcnt_reg <= bitcnt_next;
            count_reg  <= count_next;
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (emit)
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            val_reg     <= ctrl.last ? '0 : VALUE_W'(cand_reg);
            last_reg    <= ctrl.last;
            cnt_out_reg <= ctrl.last ? count_reg : count_reg + 1'b1;
        end
    end

    assign out_valid   = ov_reg;
    assign prime_value = val_reg;
    assign is_last     = last_reg;
    assign prime_count = cnt_out_reg;

endmodule

>>> hw/rtl/trial_division_prime_lister_unit.sv
// ----------------------------------------------------------------------------
// trial_division_prime_lister_unit
// Lists every prime below a given limit, then a terminating word.
// ----------------------------------------------------------------------------
// One limit word starts a run; the unit takes no new limit until the run's
// terminating word has been handed to the output register. Each candidate
// below the limit takes a bound check and a step to the next candidate (plus
// the passing square check and the emit when it is prime), and each trial
// divisor whose remainder is computed adds a 9-step bit-serial remainder loop
// with its setup and divisor step, run by the microcode sequencer. A run also
// has the load, the final bound check and the terminating word; a limit of 2
// or less yields only the terminating word. Output stalls can hold a run.
// Primes come out in ascending order with a running count; the last word has
// value 0, is_last set and the total count. Limits above MAX_LIMIT are
// clamped to MAX_LIMIT.
module trial_division_prime_lister_unit
    import tdpl_pkg::*;
#(
    parameter int MAX_LIMIT = MAX_LIMIT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [LIMIT_W-1:0] limit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [VALUE_W-1:0] prime_value,
    output logic               is_last,
    output logic [COUNT_W-1:0] prime_count
);

    ctrl_t ctrl;
    stat_t stat;
    logic  idle;

    assign in_stall = !idle;

    tdpl_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctrl     (ctrl),
        .idle     (idle)
    );

    tdpl_datapath #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .limit       (limit),
        .out_stall   (out_stall),
        .stat        (stat),
        .out_valid   (out_valid),
        .prime_value (prime_value),
        .is_last     (is_last),
        .prime_count (prime_count)
    );

endmodule

>>> hw/rtl/tdpl_checker.sv
// ----------------------------------------------------------------------------
// tdpl_checker
// Port-level checks for the prime lister, bound to the top level.
// ----------------------------------------------------------------------------
module tdpl_checker
    import tdpl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [VALUE_W-1:0] prime_value,
    input logic               is_last,
    input logic [COUNT_W-1:0] prime_count
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(prime_value)
            && $stable(is_last) && $stable(prime_count))
        else $error("stalled output word changed");

    // An accepted limit starts a run that blocks further limits
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // Terminating word carries value 0
    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_last |-> prime_value == '0)
        else $error("terminating word has nonzero value");

    // A prime word has a value of at least 2 and a nonzero count
    a_prime_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |-> prime_value >= VALUE_W'(2) && prime_count != '0)
        else $error("bad prime word");

endmodule

bind trial_division_prime_lister_unit tdpl_checker u_tdpl_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .prime_value (prime_value),
    .is_last     (is_last),
    .prime_count (prime_count)
);
